// ===== design/vfm_pkg.sv =====
// Shared constants, types and face codes of the voxel face mask unit.
package vfm_pkg;

    // Chunk geometry and voxel width
    parameter int CHUNK_EDGE = 32;
    parameter int VOXEL_BITS = 8;

    // Width of one voxel field on the ports
    parameter int FIELD_W = 8;
    parameter int INDEX_W = 16;

    parameter int PAD      = CHUNK_EDGE + 1;
    parameter int EDGE_MAX = CHUNK_EDGE - 1;
    parameter int COORD_W  = (CHUNK_EDGE > 1) ? $clog2(CHUNK_EDGE) : 1;
    parameter int PLANE    = CHUNK_EDGE * CHUNK_EDGE;
    parameter int PLANE_W  = $clog2(PLANE);
    parameter int IDX_W    = $clog2(PAD * PAD * PAD);

    // Increments of the padded index when x, y or z steps
    parameter int STEP_X = 1;
    parameter int STEP_Y = PAD - EDGE_MAX;
    parameter int STEP_Z = PAD * PAD - EDGE_MAX * PAD - EDGE_MAX;

    // Offsets to the face neighbor along each axis
    parameter int OFS_X = 1;
    parameter int OFS_Y = PAD;
    parameter int OFS_Z = PAD * PAD;

    parameter logic [FIELD_W-1:0] VOXEL_MASK = FIELD_W'((1 << VOXEL_BITS) - 1);

    parameter int S_DATA_W = 4 * FIELD_W;
    parameter int M_DATA_W = INDEX_W + FIELD_W;

    // Face codes, in the order the writes of one voxel go out
    parameter int NUM_FACES    = 6;
    parameter int FACE_LOW_X   = 0;
    parameter int FACE_LOW_Y   = 1;
    parameter int FACE_LOW_Z   = 2;
    parameter int FACE_HIGH_X  = 3;
    parameter int FACE_HIGH_Y  = 4;
    parameter int FACE_HIGH_Z  = 5;

    typedef logic [FIELD_W-1:0] voxel_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [IDX_W-1:0]   idx_t;

    // One voxel held for face evaluation
    typedef struct packed {
        voxel_t cur;
        voxel_t beyond_x;
        voxel_t beyond_y;
        voxel_t beyond_z;
        voxel_t lower_x;
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        idx_t   base;
    } item_t;

    // Candidate mask writes of one voxel
    typedef struct packed {
        logic [NUM_FACES-1:0]              en;
        logic [NUM_FACES-1:0][IDX_W-1:0]   idx;
        logic [NUM_FACES-1:0][FIELD_W-1:0] val;
    } face_set_t;

endpackage

// ===== design/vfm_ram.sv =====
// Single-port read-first RAM with registered read data.
module vfm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read old contents and write new ones at the same address
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg     <= mem_reg[addr];
            mem_reg[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/vfm_face_eval.sv =====
// Face pair tests of one voxel against its six face neighbors.
module vfm_face_eval (
    input  vfm_pkg::item_t     item,
    input  vfm_pkg::voxel_t    lower_y,
    input  vfm_pkg::voxel_t    lower_z,
    output vfm_pkg::face_set_t faces
);

    logic cur_solid;
    logic lx_solid, ly_solid, lz_solid;
    logic bx_solid, by_solid, bz_solid;
    logic x_low, y_low, z_low;
    logic x_high, y_high, z_high;

    always_comb begin
        cur_solid = item.cur != '0;
        lx_solid  = item.lower_x != '0;
        ly_solid  = lower_y != '0;
        lz_solid  = lower_z != '0;
        bx_solid  = item.beyond_x != '0;
        by_solid  = item.beyond_y != '0;
        bz_solid  = item.beyond_z != '0;

        x_low  = item.pos_x != '0;
        y_low  = item.pos_y != '0;
        z_low  = item.pos_z != '0;
        x_high = item.pos_x == vfm_pkg::COORD_W'(vfm_pkg::EDGE_MAX);
        y_high = item.pos_y == vfm_pkg::COORD_W'(vfm_pkg::EDGE_MAX);
        z_high = item.pos_z == vfm_pkg::COORD_W'(vfm_pkg::EDGE_MAX);

        // Lower neighbors: solid side is the neighbor or this voxel
        faces.en[vfm_pkg::FACE_LOW_X]  = x_low && (lx_solid != cur_solid);
        faces.idx[vfm_pkg::FACE_LOW_X] = lx_solid
            ? item.base - vfm_pkg::IDX_W'(vfm_pkg::OFS_X) : item.base;
        faces.val[vfm_pkg::FACE_LOW_X] = item.lower_x | item.cur;

        faces.en[vfm_pkg::FACE_LOW_Y]  = y_low && (ly_solid != cur_solid);
        faces.idx[vfm_pkg::FACE_LOW_Y] = ly_solid
            ? item.base - vfm_pkg::IDX_W'(vfm_pkg::OFS_Y) : item.base;
        faces.val[vfm_pkg::FACE_LOW_Y] = lower_y | item.cur;

        faces.en[vfm_pkg::FACE_LOW_Z]  = z_low && (lz_solid != cur_solid);
        faces.idx[vfm_pkg::FACE_LOW_Z] = lz_solid
            ? item.base - vfm_pkg::IDX_W'(vfm_pkg::OFS_Z) : item.base;
        faces.val[vfm_pkg::FACE_LOW_Z] = lower_z | item.cur;

        // High faces: compare with the neighbor chunk
        faces.en[vfm_pkg::FACE_HIGH_X]  = x_high && (bx_solid != cur_solid);
        faces.idx[vfm_pkg::FACE_HIGH_X] = cur_solid
            ? item.base : item.base + vfm_pkg::IDX_W'(vfm_pkg::OFS_X);
        faces.val[vfm_pkg::FACE_HIGH_X] = item.beyond_x | item.cur;

        faces.en[vfm_pkg::FACE_HIGH_Y]  = y_high && (by_solid != cur_solid);
        faces.idx[vfm_pkg::FACE_HIGH_Y] = cur_solid
            ? item.base : item.base + vfm_pkg::IDX_W'(vfm_pkg::OFS_Y);
        faces.val[vfm_pkg::FACE_HIGH_Y] = item.beyond_y | item.cur;

        faces.en[vfm_pkg::FACE_HIGH_Z]  = z_high && (bz_solid != cur_solid);
        faces.idx[vfm_pkg::FACE_HIGH_Z] = cur_solid
            ? item.base : item.base + vfm_pkg::IDX_W'(vfm_pkg::OFS_Z);
        faces.val[vfm_pkg::FACE_HIGH_Z] = item.beyond_z | item.cur;
    end

endmodule

// ===== design/voxel_face_mask_unit.sv =====
// Top level of the voxel face mask unit: stream ports, delay stores, write sequencing.
//
// Voxels of one cubic chunk enter in raster order (x fastest, then y, then z),
// each with the neighbor-chunk voxels past the high x, y and z faces. For every
// face-adjacent pair where exactly one voxel is nonzero, the unit emits one mask
// write: the padded (edge+1)^3 index of the solid voxel and its value, tlast on
// the final write caused by a voxel. Writes of one voxel go out as lower x, y, z
// pairs, then high x, y, z faces. Unless the output stalls, an item causing zero or
// one write does not hold the input, so voxels stream at one per clock; one causing
// more writes holds the input until its last write is loaded, as the output port
// carries one write per cycle. The lower y neighbor comes from a line buffer of edge
// entries and the lower z neighbor from a plane store of edge^2 entries, both
// single-port RAMs read and written in the accept cycle. No clearing pass follows
// reset: old entries are read only at y or z zero, where the face is masked off.
// Coordinates wrap after a chunk's last voxel, and the next item starts a new chunk.
module voxel_face_mask_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // voxel [7:0], beyond_x [15:8], beyond_y [23:16], beyond_z [31:24]
    input  logic [vfm_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // mask_index [15:0], mask_value [23:16]
    output logic [vfm_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    localparam int F = vfm_pkg::FIELD_W;

    logic                           s_accept;
    vfm_pkg::voxel_t                in_voxel, in_bx, in_by, in_bz;

    // Position counters and running padded index
    vfm_pkg::coord_t                pos_x_reg, pos_y_reg, pos_z_reg;
    vfm_pkg::coord_t                pos_x_next, pos_y_next, pos_z_next;
    logic [vfm_pkg::PLANE_W-1:0]    slot_reg, slot_next;
    vfm_pkg::idx_t                  base_reg, base_next;
    logic                           x_end, y_end, z_end;

    vfm_pkg::voxel_t                last_voxel_reg;
    vfm_pkg::voxel_t                lower_y, lower_z;

    // Evaluation stage
    vfm_pkg::item_t                 item_reg;
    logic                           st_vld_reg, st_vld_next;
    logic [vfm_pkg::NUM_FACES-1:0]  done_reg, done_next;
    vfm_pkg::face_set_t             faces;
    logic [vfm_pkg::NUM_FACES-1:0]  pend, sel;
    logic                           pend_any, is_last, out_load;
    vfm_pkg::idx_t                  sel_idx;
    vfm_pkg::voxel_t                sel_val;

    // Output register
    logic                           m_valid_reg, m_valid_next;
    logic [vfm_pkg::INDEX_W-1:0]    m_index_reg;
    vfm_pkg::voxel_t                m_value_reg;
    logic                           m_last_reg;

    assign s_accept = s_tvalid && s_tready;
    assign in_voxel = s_tdata[F-1:0]     & vfm_pkg::VOXEL_MASK;
    assign in_bx    = s_tdata[2*F-1:F]   & vfm_pkg::VOXEL_MASK;
    assign in_by    = s_tdata[3*F-1:2*F] & vfm_pkg::VOXEL_MASK;
    assign in_bz    = s_tdata[4*F-1:3*F] & vfm_pkg::VOXEL_MASK;

    // Coordinate stepping in raster order
    always_comb begin
        x_end = pos_x_reg == vfm_pkg::COORD_W'(vfm_pkg::EDGE_MAX);
        y_end = pos_y_reg == vfm_pkg::COORD_W'(vfm_pkg::EDGE_MAX);
        z_end = pos_z_reg == vfm_pkg::COORD_W'(vfm_pkg::EDGE_MAX);
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        slot_next  = (x_end && y_end) ? '0 : slot_reg + vfm_pkg::PLANE_W'(1);
        if (!x_end) begin
            pos_x_next = pos_x_reg + vfm_pkg::COORD_W'(1);
            base_next  = base_reg + vfm_pkg::IDX_W'(vfm_pkg::STEP_X);
        end else if (!y_end) begin
            pos_x_next = '0;
            pos_y_next = pos_y_reg + vfm_pkg::COORD_W'(1);
            base_next  = base_reg + vfm_pkg::IDX_W'(vfm_pkg::STEP_Y);
        end else if (!z_end) begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = pos_z_reg + vfm_pkg::COORD_W'(1);
            base_next  = base_reg + vfm_pkg::IDX_W'(vfm_pkg::STEP_Z);
        end else begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
            base_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            slot_reg  <= '0;
            base_reg  <= '0;
        end else if (s_accept) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            slot_reg  <= slot_next;
            base_reg  <= base_next;
        end
    end

    // Line buffer gives the lower y neighbor, plane store the lower z neighbor
    vfm_ram #(
        .DEPTH (vfm_pkg::CHUNK_EDGE),
        .WIDTH (F)
    ) u_line_ram (
        .aclk  (aclk),
        .en    (s_accept),
        .addr  (pos_x_reg),
        .wdata (in_voxel),
        .rdata (lower_y)
    );

    vfm_ram #(
        .DEPTH (vfm_pkg::PLANE),
        .WIDTH (F)
    ) u_plane_ram (
        .aclk  (aclk),
        .en    (s_accept),
        .addr  (slot_reg),
        .wdata (in_voxel),
        .rdata (lower_z)
    );

    // Stage payload; the previous voxel is the lower x neighbor
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            last_voxel_reg    <= in_voxel;
            item_reg.cur      <= in_voxel;
            item_reg.beyond_x <= in_bx;
            item_reg.beyond_y <= in_by;
            item_reg.beyond_z <= in_bz;
            item_reg.lower_x  <= last_voxel_reg;
            item_reg.pos_x    <= pos_x_reg;
            item_reg.pos_y    <= pos_y_reg;
            item_reg.pos_z    <= pos_z_reg;
            item_reg.base     <= base_reg;
        end
    end

    vfm_face_eval u_face_eval (
        .item    (item_reg),
        .lower_y (lower_y),
        .lower_z (lower_z),
        .faces   (faces)
    );

    // Pick the next pending write, lowest face code first
    always_comb begin
        pend     = faces.en & ~done_reg & {vfm_pkg::NUM_FACES{st_vld_reg}};
        pend_any = pend != '0;
        sel      = pend & (~pend + vfm_pkg::NUM_FACES'(1));
        is_last  = (pend & ~sel) == '0;
        out_load = pend_any && (!m_valid_reg || m_tready);
        s_tready = !st_vld_reg || !pend_any || (out_load && is_last);
        sel_idx  = '0;
        sel_val  = '0;
        for (int i = 0; i < vfm_pkg::NUM_FACES; i++) begin
            sel_idx = sel_idx | (faces.idx[i] & {vfm_pkg::IDX_W{sel[i]}});
            sel_val = sel_val | (faces.val[i] & {F{sel[i]}});
        end
    end

    // Stage occupancy and the writes already sent
    always_comb begin
        st_vld_next = st_vld_reg;
        done_next   = done_reg;
        if (s_accept) begin
            st_vld_next = 1'b1;
            done_next   = '0;
        end else if (!pend_any || (out_load && is_last)) begin
            st_vld_next = 1'b0;
        end else if (out_load) begin
            done_next = done_reg | sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= 1'b0;
            done_reg   <= '0;
        end else begin
            st_vld_reg <= st_vld_next;
            done_reg   <= done_next;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index_reg <= vfm_pkg::INDEX_W'(sel_idx);
            m_value_reg <= sel_val;
            m_last_reg  <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_value_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Padded index restarts with the coordinates
    a_base_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_x_reg == '0 && pos_y_reg == '0 && pos_z_reg == '0) |-> base_reg == '0)
        else $error("padded index not zero at chunk origin");

    // Plane slot tracks the in-plane position
    a_slot_track: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg == vfm_pkg::PLANE_W'(32'(pos_y_reg) * vfm_pkg::CHUNK_EDGE
                                      + 32'(pos_x_reg)))
        else $error("plane slot out of step with position");

    // Exactly one face goes out per output load
    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> $onehot(sel))
        else $error("face select not one-hot");

    // A new item never displaces unsent writes
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && st_vld_reg) |-> (!pend_any || (out_load && is_last)))
        else $error("pending writes lost on accept");

    // Every write carries a solid material
    a_value_solid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[vfm_pkg::M_DATA_W-1:vfm_pkg::INDEX_W] != '0)
        else $error("mask write with empty material");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the voxel face mask unit: stream stimulus, face predictor, checks.
`timescale 1ns / 100ps

module testbench;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // One expected mask write
    typedef struct {
        logic [vfm_pkg::INDEX_W-1:0] index;
        vfm_pkg::voxel_t             value;
        logic                        last;
    } mask_write_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [vfm_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [vfm_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tlast;

    // Face predictor state: its own copy of the plane store and coordinates
    vfm_pkg::voxel_t plane_copy [vfm_pkg::PLANE];
    int              face_x = 0;
    int              face_y = 0;
    int              face_z = 0;
    mask_write_t     held_write;
    bit              held_valid;
    int              voxel_writes;
    int              max_writes_per_voxel = 0;
    mask_write_t     expected_writes [$];

    // Run bookkeeping
    int items_sent = 0;
    int writes_checked = 0;
    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    voxel_face_mask_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random stalls on the result side
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    // Queue one write if exactly one voxel of the pair is solid; the latest
    // write of this voxel is held back so the final one can carry last
    task automatic add_face(input vfm_pkg::voxel_t lo, input vfm_pkg::voxel_t hi,
                            input int x, input int y, input int z, input int axis);
        mask_write_t w;
        int mx, my, mz;
        if ((lo == '0) == (hi == '0))
            return;
        mx = x;
        my = y;
        mz = z;
        // solid side is the upper voxel when the lower one is empty
        if (lo == '0) begin
            case (axis)
                AXIS_X: mx++;
                AXIS_Y: my++;
                default: mz++;
            endcase
        end
        w.index = vfm_pkg::INDEX_W'((mz * vfm_pkg::PAD + my) * vfm_pkg::PAD + mx);
        w.value = lo | hi;
        w.last  = 1'b0;
        if (held_valid)
            expected_writes.push_back(held_write);
        held_write = w;
        held_valid = 1'b1;
        voxel_writes++;
    endtask

    // Expected mask writes of one accepted voxel item
    task automatic predict_faces(input logic [vfm_pkg::S_DATA_W-1:0] data);
        vfm_pkg::voxel_t cur, bx, by, bz;
        int              slot;
        cur = data[0 +: vfm_pkg::FIELD_W] & vfm_pkg::VOXEL_MASK;
        bx  = data[vfm_pkg::FIELD_W +: vfm_pkg::FIELD_W] & vfm_pkg::VOXEL_MASK;
        by  = data[2*vfm_pkg::FIELD_W +: vfm_pkg::FIELD_W] & vfm_pkg::VOXEL_MASK;
        bz  = data[3*vfm_pkg::FIELD_W +: vfm_pkg::FIELD_W] & vfm_pkg::VOXEL_MASK;
        slot = face_y * vfm_pkg::CHUNK_EDGE + face_x;
        held_valid = 1'b0;
        voxel_writes = 0;

        // lower neighbors in axis order
        if (face_x > 0)
            add_face(plane_copy[slot - 1], cur, face_x - 1, face_y, face_z, AXIS_X);
        if (face_y > 0)
            add_face(plane_copy[slot - vfm_pkg::CHUNK_EDGE], cur,
                     face_x, face_y - 1, face_z, AXIS_Y);
        if (face_z > 0)
            add_face(plane_copy[slot], cur, face_x, face_y, face_z - 1, AXIS_Z);

        // high faces against the neighbor chunk
        if (face_x == vfm_pkg::EDGE_MAX)
            add_face(cur, bx, face_x, face_y, face_z, AXIS_X);
        if (face_y == vfm_pkg::EDGE_MAX)
            add_face(cur, by, face_x, face_y, face_z, AXIS_Y);
        if (face_z == vfm_pkg::EDGE_MAX)
            add_face(cur, bz, face_x, face_y, face_z, AXIS_Z);

        if (held_valid) begin
            held_write.last = 1'b1;
            expected_writes.push_back(held_write);
        end
        if (voxel_writes > max_writes_per_voxel)
            max_writes_per_voxel = voxel_writes;

        plane_copy[slot] = cur;

        // raster advance, wrapping after the last voxel of a chunk
        if (face_x == vfm_pkg::EDGE_MAX) begin
            face_x = 0;
            if (face_y == vfm_pkg::EDGE_MAX) begin
                face_y = 0;
                face_z = (face_z == vfm_pkg::EDGE_MAX) ? 0 : face_z + 1;
            end else begin
                face_y++;
            end
        end else begin
            face_x++;
        end
    endtask

    // Predict on every accepted voxel, then check every accepted write
    always @(posedge aclk) begin : monitor
        mask_write_t want;
        if (aresetn && s_tvalid && s_tready)
            predict_faces(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_writes.size() == 0) begin
                $error("unexpected mask write: index %0d value %0d last %0b",
                       m_tdata[vfm_pkg::INDEX_W-1:0],
                       m_tdata[vfm_pkg::INDEX_W +: vfm_pkg::FIELD_W], m_tlast);
                fail_count++;
            end else begin
                want = expected_writes.pop_front();
                writes_checked++;
                if (m_tdata[vfm_pkg::INDEX_W-1:0] !== want.index) begin
                    $error("mask_index: expected %0d, got %0d",
                           want.index, m_tdata[vfm_pkg::INDEX_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[vfm_pkg::INDEX_W +: vfm_pkg::FIELD_W] !== want.value) begin
                    $error("mask_value: expected %0d, got %0d",
                           want.value, m_tdata[vfm_pkg::INDEX_W +: vfm_pkg::FIELD_W]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Coordinate of the next voxel to send
    function automatic int stream_coord(input int axis);
        case (axis)
            AXIS_X: return items_sent % vfm_pkg::CHUNK_EDGE;
            AXIS_Y: return (items_sent / vfm_pkg::CHUNK_EDGE) % vfm_pkg::CHUNK_EDGE;
            default: return (items_sent / vfm_pkg::PLANE) % vfm_pkg::CHUNK_EDGE;
        endcase
    endfunction

    // Empty, or a material with extremes favored
    function automatic vfm_pkg::voxel_t pick_voxel(input int density);
        vfm_pkg::voxel_t v;
        v = '0;
        if (int'($urandom_range(99)) < density) begin
            case ($urandom_range(9))
                0: v = 8'hFF;
                1: v = 8'h01;
                default: v = vfm_pkg::voxel_t'($urandom_range(255, 1));
            endcase
        end
        return v;
    endfunction

    // Fill density for a row: empty, sparse, noisy, dense or full
    function automatic int row_density();
        case ($urandom_range(4))
            0: return 0;
            1: return 10;
            2: return 50;
            3: return 90;
            default: return 100;
        endcase
    endfunction

    // Idling mode: none, sender idle, receiver stalling, both
    task automatic apply_phase(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    // Send one voxel item; entered and left at a falling edge
    task automatic send_voxel(input vfm_pkg::voxel_t v, input vfm_pkg::voxel_t bx,
                              input vfm_pkg::voxel_t by, input vfm_pkg::voxel_t bz);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bz, by, bx, v};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Random voxel; beyond fields are real neighbors at the high faces, noise elsewhere
    task automatic send_random(input int density);
        vfm_pkg::voxel_t bx, by, bz;
        bx = (stream_coord(AXIS_X) == vfm_pkg::EDGE_MAX)
            ? pick_voxel(50) : vfm_pkg::voxel_t'($urandom_range(255));
        by = (stream_coord(AXIS_Y) == vfm_pkg::EDGE_MAX)
            ? pick_voxel(50) : vfm_pkg::voxel_t'($urandom_range(255));
        bz = (stream_coord(AXIS_Z) == vfm_pkg::EDGE_MAX)
            ? pick_voxel(50) : vfm_pkg::voxel_t'($urandom_range(255));
        send_voxel(pick_voxel(density), bx, by, bz);
    endtask

    // Chunk origin: every solid/empty transition with extreme materials
    task automatic test_directed_start();
        vfm_pkg::voxel_t pattern [24] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h80,
                                          8'h7F, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h00, 8'h00,
                                          8'hFE, 8'h00, 8'h55, 8'hAA, 8'h00, 8'h02, 8'h00,
                                          8'h40, 8'h20, 8'h00};
        vfm_pkg::voxel_t fill [4] = '{8'hFF, 8'h00, 8'hAA, 8'h55};
        apply_phase(0);
        for (int n = 0; n < 24; n++)
            send_voxel(pattern[n], fill[n % 4], fill[(n + 1) % 4], fill[(n + 2) % 4]);
    endtask

    // Random rows of the first plane under each idling mode
    task automatic test_random_rows();
        int density;
        density = 50;
        for (int n = 0; n < 296; n++) begin
            if (n % 74 == 0)
                apply_phase(n / 74);
            if (stream_coord(AXIS_X) == 0)
                density = row_density();
            send_random(density);
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        for (int i = 0; i < vfm_pkg::PLANE; i++)
            plane_copy[i] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_start();
        test_random_rows();

        // drain
        s_tvalid <= 1'b0;
        apply_phase(0);
        while (expected_writes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Streamed %0d voxels over the first rows of a chunk, high x face included,",
                 items_sent);
        $display("under four idling modes; checked %0d mask writes, busiest voxel gave %0d.",
                 writes_checked, max_writes_per_voxel);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/vfm_pkg.sv
design/vfm_ram.sv
design/vfm_face_eval.sv
design/voxel_face_mask_unit.sv
verif/testbench.sv
